// ===== hw/rtl/vce_pkg.sv =====
`default_nettype none

package vce_pkg;

   localparam int ALPHABET_DEPTH_DEFAULT = 64;
   localparam int KEY_DEPTH_DEFAULT      = 32;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [6:0] ALPHABET_LEN_RESET = 7'd26;
   localparam logic [5:0] KEY_LEN_RESET      = 6'd1;
   localparam logic       DECRYPT_RESET      = 1'b0;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_ALPHABET_LEN = 2'd0;
   localparam logic [1:0] REG_KEY_LEN      = 2'd1;
   localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

   // Operation codes of an input word.
   localparam logic [1:0] OP_LOAD_ALPHABET = 2'd0;
   localparam logic [1:0] OP_LOAD_KEY      = 2'd1;
   localparam logic [1:0] OP_MESSAGE       = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_KEY  = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_CALC = 5'b01000,
      ST_READ = 5'b10000
   } vce_state_type;

   typedef struct packed {
      logic write_alphabet;
      logic write_key;
      logic accept_message;
      logic scan_start;
      logic scan_step;
      logic calc;
      logic load_out;
   } vce_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } vce_status_type;

   typedef struct packed {
      logic [6:0] alphabet_len;
      logic [5:0] key_len;
      logic       decrypt_mode;
   } vce_cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/vce_ram.sv =====
`default_nettype none

module vce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vce_csr.sv =====
`default_nettype none

module vce_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [vce_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [vce_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [vce_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready,
   output vce_pkg::vce_cfg_type                   cfg
);

   import vce_pkg::*;

   vce_cfg_type cfg_ff;
   logic [1:0]  reg_index;
   logic        write_en;

   assign reg_index = paddr[3:2];
   assign write_en  = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alphabet_len <= ALPHABET_LEN_RESET;
         cfg_ff.key_len      <= KEY_LEN_RESET;
         cfg_ff.decrypt_mode <= DECRYPT_RESET;
      end else if (write_en) begin
         case (reg_index)
            REG_ALPHABET_LEN: cfg_ff.alphabet_len <= pwdata[6:0];
            REG_KEY_LEN:      cfg_ff.key_len      <= pwdata[5:0];
            REG_DECRYPT_MODE: cfg_ff.decrypt_mode <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ALPHABET_LEN: prdata = CSR_DATA_W'(cfg_ff.alphabet_len);
         REG_KEY_LEN:      prdata = CSR_DATA_W'(cfg_ff.key_len);
         REG_DECRYPT_MODE: prdata = CSR_DATA_W'(cfg_ff.decrypt_mode);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vce_ctrl.sv =====
`default_nettype none

module vce_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [1:0]             req_op,
   output logic                        req_stall,
   input  wire vce_pkg::vce_status_type sts,
   output vce_pkg::vce_cmd_type        cmd
);

   import vce_pkg::*;

   vce_state_type state_ff;
   vce_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_LOAD_ALPHABET: cmd.write_alphabet = 1'b1;
                  OP_LOAD_KEY:      cmd.write_key      = 1'b1;
                  OP_MESSAGE: begin
                     cmd.accept_message = 1'b1;
                     state_in           = ST_KEY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_KEY: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            // The result waits here until the output register can take it.
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded while the output register is occupied");

   a_message_starts_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_message |=> (state_ff == ST_KEY) ##1 (state_ff == ST_SCAN))
      else $error("message word did not start a key read and scan");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/vce_dp.sv =====
`default_nettype none

module vce_dp #(
   parameter int ALPHABET_DEPTH = vce_pkg::ALPHABET_DEPTH_DEFAULT,
   parameter int KEY_DEPTH      = vce_pkg::KEY_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire vce_pkg::vce_cmd_type    cmd,
   input  wire vce_pkg::vce_cfg_type    cfg,
   input  wire logic [5:0]              req_slot,
   input  wire logic [7:0]              req_char_in,
   input  wire logic                    req_first,
   output vce_pkg::vce_status_type      sts,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [7:0]                   rsp_char_out,
   output logic                         rsp_not_found
);

   import vce_pkg::*;

   localparam int AW  = $clog2(ALPHABET_DEPTH);
   localparam int NW  = AW + 1;
   localparam int KW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int KNW = KW + 1;

   // Effective lengths after clamping to 1..depth.
   logic [NW-1:0]  alph_n;
   logic [KNW-1:0] key_n;

   always_comb begin
      if (cfg.alphabet_len == '0) begin
         alph_n = NW'(1);
      end else if (32'(cfg.alphabet_len) > ALPHABET_DEPTH) begin
         alph_n = NW'(ALPHABET_DEPTH);
      end else begin
         alph_n = NW'(cfg.alphabet_len);
      end
      if (cfg.key_len == '0) begin
         key_n = KNW'(1);
      end else if (32'(cfg.key_len) > KEY_DEPTH) begin
         key_n = KNW'(KEY_DEPTH);
      end else begin
         key_n = KNW'(cfg.key_len);
      end
   end

   // Key position.
   logic [KW-1:0]  key_pos_ff;
   logic [KW-1:0]  key_pos_in;
   logic [KW-1:0]  pos_cur;
   logic [KNW-1:0] pos_next_wide;

   always_comb begin
      if (req_first || (KNW'(key_pos_ff) >= key_n)) begin
         pos_cur = '0;
      end else begin
         pos_cur = key_pos_ff;
      end
      pos_next_wide = KNW'(pos_cur) + KNW'(1);
      key_pos_in    = (pos_next_wide >= key_n) ? '0 : pos_next_wide[KW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= '0;
      end else if (cmd.accept_message) begin
         key_pos_ff <= key_pos_in;
      end
   end

   // Key store.
   logic       key_wr_en;
   logic [7:0] key_rd_data;

   assign key_wr_en = cmd.write_key && (32'(req_slot) < KEY_DEPTH);

   vce_ram #(
      .WIDTH(8),
      .DEPTH(KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (KW'(req_slot)),
      .wr_data (req_char_in),
      .rd_en   (cmd.accept_message),
      .rd_addr (pos_cur),
      .rd_data (key_rd_data)
   );

   // Alphabet table.
   logic          alph_wr_en;
   logic          alph_rd_en;
   logic [AW-1:0] alph_rd_addr;
   logic [7:0]    alph_rd_data;

   assign alph_wr_en = cmd.write_alphabet && (32'(req_slot) < ALPHABET_DEPTH);

   vce_ram #(
      .WIDTH(8),
      .DEPTH(ALPHABET_DEPTH)
   ) u_alph_ram (
      .clock   (clock),
      .wr_en   (alph_wr_en),
      .wr_addr (AW'(req_slot)),
      .wr_data (req_char_in),
      .rd_en   (alph_rd_en),
      .rd_addr (alph_rd_addr),
      .rd_data (alph_rd_data)
   );

   // Scan and result registers.
   logic [7:0]    msg_char_ff;
   logic [AW-1:0] scan_idx_ff;
   logic [AW-1:0] scan_idx_in;
   logic [NW-1:0] scan_next_wide;
   logic          msg_hit_ff, msg_hit_in;
   logic          key_hit_ff, key_hit_in;
   logic [AW-1:0] msg_idx_ff, msg_idx_in;
   logic [AW-1:0] key_idx_ff, key_idx_in;
   logic [NW-1:0] sum;
   logic [NW-1:0] sum_mod;
   logic [AW-1:0] res_idx;
   logic          both_hit;

   assign scan_next_wide = NW'(scan_idx_ff) + NW'(1);

   // Both indexes are below n, so one conditional subtract brings the sum into range.
   always_comb begin
      if (cfg.decrypt_mode) begin
         sum = NW'(msg_idx_ff) + alph_n - NW'(key_idx_ff);
      end else begin
         sum = NW'(msg_idx_ff) + NW'(key_idx_ff);
      end
      sum_mod = (sum >= alph_n) ? (sum - alph_n) : sum;
      res_idx = sum_mod[AW-1:0];
   end

   always_comb begin
      alph_rd_en   = 1'b0;
      alph_rd_addr = '0;
      scan_idx_in  = scan_idx_ff;
      msg_hit_in   = msg_hit_ff;
      key_hit_in   = key_hit_ff;
      msg_idx_in   = msg_idx_ff;
      key_idx_in   = key_idx_ff;
      if (cmd.scan_start) begin
         alph_rd_en  = 1'b1;
         scan_idx_in = '0;
         msg_hit_in  = 1'b0;
         key_hit_in  = 1'b0;
      end else if (cmd.scan_step) begin
         // Scanning upward, a later match replaces an earlier one.
         if (alph_rd_data == msg_char_ff) begin
            msg_hit_in = 1'b1;
            msg_idx_in = scan_idx_ff;
         end
         if (alph_rd_data == key_rd_data) begin
            key_hit_in = 1'b1;
            key_idx_in = scan_idx_ff;
         end
         alph_rd_en   = !sts.scan_last;
         alph_rd_addr = scan_next_wide[AW-1:0];
         scan_idx_in  = scan_next_wide[AW-1:0];
      end else if (cmd.calc) begin
         alph_rd_en   = 1'b1;
         alph_rd_addr = res_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_message) begin
         msg_char_ff <= req_char_in;
      end
      scan_idx_ff <= scan_idx_in;
      msg_hit_ff  <= msg_hit_in;
      key_hit_ff  <= key_hit_in;
      msg_idx_ff  <= msg_idx_in;
      key_idx_ff  <= key_idx_in;
   end

   // Output register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   logic       rsp_nf_ff;

   assign both_hit = msg_hit_ff && key_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_char_ff <= both_hit ? alph_rd_data : msg_char_ff;
         rsp_nf_ff   <= !both_hit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_out  = rsp_char_ff;
   assign rsp_not_found = rsp_nf_ff;

   assign sts.scan_last = (scan_next_wide >= alph_n);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

`ifndef SYNTHESIS
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (NW'(scan_idx_ff) < alph_n))
      else $error("alphabet scan ran past the alphabet length");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.calc && both_hit) |-> (sum_mod < alph_n))
      else $error("cipher index not reduced below the alphabet length");

   a_match_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.calc && msg_hit_ff) |-> (NW'(msg_idx_ff) < alph_n))
      else $error("message match index outside the alphabet");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/vigenere_cipher_engine_top.sv =====
// Vigenere cipher engine over a loadable alphabet.
// Input words arrive on req_* (valid/stall). req_op selects: load an alphabet
// entry at req_slot, load a key character at req_slot, or encipher/decipher
// the message character req_char_in (req_first restarts the key position).
// Load words produce no result and leave the input free. A message word gives
// one result word on rsp_* with the ciphered character, or the input
// character and rsp_not_found set when either it or the key character is
// not in the alphabet.
// After a message word is accepted, the key character is read and a scan reads
// the alphabet memory one entry per cycle over the effective alphabet length n,
// comparing each entry against the message and key characters. The cipher index
// is then computed and its entry read; the result waits for a free output
// register, and the input stays stalled until it is loaded and rsp_valid rises.
// Configuration registers (alphabet length, key length, decrypt mode) sit on
// the APB-style port and should be written while no message is in flight.
// Reset (synchronous, active high) clears the key position, the controller and
// the output valid, and restores the register defaults; the tables keep their
// contents and must be loaded before use. While rsp_stall is high the result
// word holds, and the engine may accept and work on one more word meanwhile.
`default_nettype none

module vigenere_cipher_engine_top #(
   parameter int ALPHABET_DEPTH = vce_pkg::ALPHABET_DEPTH_DEFAULT,
   parameter int KEY_DEPTH      = vce_pkg::KEY_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_op,
   input  wire logic [5:0]                      req_slot,
   input  wire logic [7:0]                      req_char_in,
   input  wire logic                            req_first,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_char_out,
   output logic                                 rsp_not_found,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [vce_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [vce_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [vce_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready
);

   import vce_pkg::*;

   vce_cfg_type    cfg;
   vce_cmd_type    cmd;
   vce_status_type sts;

   vce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vce_dp #(
      .ALPHABET_DEPTH (ALPHABET_DEPTH),
      .KEY_DEPTH      (KEY_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .req_slot      (req_slot),
      .req_char_in   (req_char_in),
      .req_first     (req_first),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_not_found (rsp_not_found)
   );

endmodule

`default_nettype wire

// ===== tb/vigenere_cipher_engine_top_test.sv =====
`default_nettype none

module vigenere_cipher_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vce_pkg::*;

   localparam int ALPHA_DEPTH   = ALPHABET_DEPTH_DEFAULT;
   localparam int KEY_DEPTH     = KEY_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int N_PHASES      = 12;
   localparam int N_DIRECTED    = 20;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam logic [1:0] CSR_REGS [3] = '{REG_ALPHABET_LEN, REG_KEY_LEN, REG_DECRYPT_MODE};

   // A negative entry asks for a random setting in that phase.
   localparam int PHASE_ALEN  [N_PHASES] = '{26, 26, 0, 127, 64, 1, 65, 10, -1, -1, 64, -1};
   localparam int PHASE_KLEN  [N_PHASES] = '{1, 5, 0, 63, 32, 1, 33, 7, -1, -1, 32, -1};
   localparam int PHASE_DEC   [N_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, -1, -1, 1, -1};
   localparam int PHASE_WORDS [N_PHASES] =
      '{150, 180, 180, 80, 80, 180, 80, 180, 180, 180, 80, 180};

   typedef struct packed {
      logic [7:0] char_out;
      logic       not_found;
   } cipher_out_type;

   typedef struct packed {
      logic [1:0] op;
      logic [5:0] slot;
      logic [7:0] char_in;
      logic       first;
      logic       typed;
      logic [7:0] exp_char;
      logic       exp_not_found;
   } directed_row_type;

   // Tables start out as a base64 alphabet with the key store holding its first symbols.
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      '{OP_MESSAGE,       6'd0,  "A",   1'b1, 1'b1, "A",   1'b0},
      '{OP_MESSAGE,       6'd63, "Z",   1'b0, 1'b1, "Z",   1'b0},
      '{OP_MESSAGE,       6'd0,  "a",   1'b0, 1'b1, "a",   1'b1},
      '{OP_MESSAGE,       6'd21, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
      '{OP_MESSAGE,       6'd42, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
      '{OP_LOAD_KEY,      6'd0,  "D",   1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_MESSAGE,       6'd0,  "X",   1'b1, 1'b1, "A",   1'b0},
      '{OP_MESSAGE,       6'd0,  "W",   1'b0, 1'b1, "Z",   1'b0},
      '{OP_MESSAGE,       6'd0,  "Z",   1'b0, 1'b1, "C",   1'b0},
      '{OP_LOAD_KEY,      6'd0,  "z",   1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_MESSAGE,       6'd0,  "B",   1'b1, 1'b1, "B",   1'b1},
      '{OP_LOAD_KEY,      6'd0,  "C",   1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_LOAD_ALPHABET, 6'd5,  "A",   1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_MESSAGE,       6'd0,  "A",   1'b0, 1'b1, "H",   1'b0},
      '{OP_MESSAGE,       6'd0,  "F",   1'b0, 1'b1, "F",   1'b1},
      '{OP_LOAD_ALPHABET, 6'd5,  "F",   1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_LOAD_KEY,      6'd40, "Q",   1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_RESERVED,      6'd63, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{OP_MESSAGE,       6'd0,  "C",   1'b0, 1'b1, "E",   1'b0},
      '{OP_MESSAGE,       6'd17, "M",   1'b1, 1'b0, 8'h00, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_op = OP_LOAD_ALPHABET;
   logic [5:0]            req_slot = '0;
   logic [7:0]            req_char_in = '0;
   logic                  req_first = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_char_out;
   logic                  rsp_not_found;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   vigenere_cipher_engine_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_slot      (req_slot),
      .req_char_in   (req_char_in),
      .req_first     (req_first),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_not_found (rsp_not_found),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // Shadow copy of the engine's tables, key position and registers.
   logic [7:0]  alpha_tab [ALPHA_DEPTH];
   logic [7:0]  key_tab [KEY_DEPTH];
   int          key_pos = 0;
   logic [6:0]  alpha_len_reg = ALPHABET_LEN_RESET;
   logic [5:0]  key_len_reg = KEY_LEN_RESET;
   logic        decrypt_reg = DECRYPT_RESET;

   cipher_out_type expected_chars [$];
   cipher_out_type oldest;
   int             errors = 0;
   int             words_sent = 0;
   int             chars_checked = 0;
   int             misses_checked = 0;
   int             settings_run = 1;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_chars.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, char_out %h not_found %b", $time,
                     rsp_char_out, rsp_not_found);
         end else begin
            oldest = expected_chars.pop_front();
            chars_checked++;
            if (rsp_not_found) misses_checked++;
            if (rsp_char_out !== oldest.char_out) begin
               errors++;
               $display("%0t: char_out expected %h, actual %h", $time, oldest.char_out,
                        rsp_char_out);
            end
            if (rsp_not_found !== oldest.not_found) begin
               errors++;
               $display("%0t: not_found expected %b, actual %b", $time, oldest.not_found,
                        rsp_not_found);
            end
         end
      end
   end

   function automatic int eff_alpha_len();
      if (alpha_len_reg == 0) return 1;
      return (alpha_len_reg > ALPHA_DEPTH) ? ALPHA_DEPTH : int'(alpha_len_reg);
   endfunction

   function automatic int eff_key_len();
      if (key_len_reg == 0) return 1;
      return (key_len_reg > KEY_DEPTH) ? KEY_DEPTH : int'(key_len_reg);
   endfunction

   function automatic logic [7:0] base64_symbol(input int i);
      if (i < 26) return 8'("A" + i);
      if (i < 52) return 8'("a" + i - 26);
      if (i < 62) return 8'("0" + i - 52);
      return (i == 62) ? "+" : "/";
   endfunction

   // Mostly a symbol of the live alphabet, so that lookups hit.
   function automatic logic [7:0] pick_symbol(input int hit_pct);
      if ($urandom_range(0, 99) < hit_pct)
         return alpha_tab[$urandom_range(0, eff_alpha_len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic cipher_word(input logic [1:0] op, input logic [5:0] slot,
                              input logic [7:0] ch, input logic first,
                              output bit has_out, output cipher_out_type res);
      int  n;
      int  klen;
      int  pos;
      int  mi;
      int  ki;
      int  r;
      bit  m_hit;
      bit  k_hit;
      has_out = 1'b0;
      res = '0;
      mi = 0;
      ki = 0;
      m_hit = 1'b0;
      k_hit = 1'b0;
      case (op)
         OP_LOAD_ALPHABET: begin
            alpha_tab[slot] = ch;
         end
         OP_LOAD_KEY: begin
            if (slot < KEY_DEPTH) key_tab[slot] = ch;
         end
         OP_MESSAGE: begin
            n = eff_alpha_len();
            klen = eff_key_len();
            if (first) key_pos = 0;
            // A position left over from a longer key restarts at zero.
            pos = (key_pos < klen) ? key_pos : 0;
            for (int j = 0; j < n; j++) begin
               if (alpha_tab[j] == ch) begin
                  mi = j;
                  m_hit = 1'b1;
               end
               if (alpha_tab[j] == key_tab[pos]) begin
                  ki = j;
                  k_hit = 1'b1;
               end
            end
            if (m_hit && k_hit) begin
               r = decrypt_reg ? (mi + n - ki) % n : (mi + ki) % n;
               res.char_out = alpha_tab[r];
               res.not_found = 1'b0;
            end else begin
               res.char_out = ch;
               res.not_found = 1'b1;
            end
            key_pos = (pos + 1 >= klen) ? 0 : pos + 1;
            has_out = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic send_word(input logic [1:0] op, input logic [5:0] slot,
                            input logic [7:0] ch, input logic first,
                            input bit typed, input cipher_out_type typed_res);
      bit             has_out;
      cipher_out_type res;
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_slot <= slot;
      req_char_in <= ch;
      req_first <= first;
      do @(posedge clock); while (req_stall);
      cipher_word(op, slot, ch, first, has_out, res);
      if (has_out) expected_chars.push_back(typed ? typed_res : res);
      if (op != OP_RESERVED && !(op == OP_LOAD_KEY && slot >= KEY_DEPTH)) words_sent++;
   endtask

   // Lets every expected word arrive, then gives trailing loads time to finish.
   task automatic drain_engine();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ALPHABET_LEN: alpha_len_reg = value[6:0];
         REG_KEY_LEN:      key_len_reg = value[5:0];
         REG_DECRYPT_MODE: decrypt_reg = value[0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_check(input logic [1:0] idx);
      logic [CSR_DATA_W-1:0] want;
      logic [CSR_DATA_W-1:0] mask;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ALPHABET_LEN: begin
            want = CSR_DATA_W'(alpha_len_reg);
            mask = 'h7F;
         end
         REG_KEY_LEN: begin
            want = CSR_DATA_W'(key_len_reg);
            mask = 'h3F;
         end
         default: begin
            want = CSR_DATA_W'(decrypt_reg);
            mask = 'h1;
         end
      endcase
      if ((prdata & mask) !== want) begin
         errors++;
         $display("%0t: register %0d read expected %h, actual %h", $time, idx, want,
                  prdata & mask);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int             phase_start;
      int             len;
      int             sel;
      int             alen;
      int             klen;
      int             dec;
      cipher_out_type typed_res;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (CSR_REGS[i]) csr_check(CSR_REGS[i]);

      for (int phase = 0; phase < N_PHASES; phase++) begin
         case (phase / 4)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 52;
            end
            1: begin
               send_idle_pct = 52;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         if (phase == 0) begin
            // Every table entry gets written before the first lookup.
            for (int i = 0; i < ALPHA_DEPTH; i++)
               send_word(OP_LOAD_ALPHABET, 6'(i), base64_symbol(i), 1'b0, 1'b0, '0);
            for (int i = 0; i < KEY_DEPTH; i++)
               send_word(OP_LOAD_KEY, 6'(i), base64_symbol(i), 1'b0, 1'b0, '0);
            foreach (DIRECTED[i]) begin
               typed_res.char_out = DIRECTED[i].exp_char;
               typed_res.not_found = DIRECTED[i].exp_not_found;
               send_word(DIRECTED[i].op, DIRECTED[i].slot, DIRECTED[i].char_in,
                         DIRECTED[i].first, DIRECTED[i].typed, typed_res);
            end
         end else begin
            drain_engine();
            alen = PHASE_ALEN[phase];
            klen = PHASE_KLEN[phase];
            dec = PHASE_DEC[phase];
            if (alen < 0) begin
               alen = (phase == N_PHASES - 1) ? $urandom_range(0, 127) : $urandom_range(2, 40);
               klen = (phase == N_PHASES - 1) ? $urandom_range(0, 63) : $urandom_range(1, 32);
               dec = $urandom_range(0, 1);
            end
            csr_write(REG_ALPHABET_LEN, CSR_DATA_W'(alen));
            csr_write(REG_KEY_LEN, CSR_DATA_W'(klen));
            csr_write(REG_DECRYPT_MODE, CSR_DATA_W'(dec));
            foreach (CSR_REGS[i]) csr_check(CSR_REGS[i]);
            settings_run++;
            // Continuing an old message exercises a key position left beyond a shorter key.
            send_word(OP_MESSAGE, 6'($urandom_range(0, 63)), pick_symbol(100), 1'b0, 1'b0, '0);
         end

         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS[phase]) begin
            sel = $urandom_range(0, 99);
            if (sel < 72) begin
               len = $urandom_range(1, 10);
               for (int k = 0; k < len; k++) begin
                  if ($urandom_range(0, 99) < 6)
                     send_word(OP_LOAD_KEY, 6'($urandom_range(0, eff_key_len() - 1)),
                               pick_symbol(80), 1'b0, 1'b0, '0);
                  send_word(OP_MESSAGE, 6'($urandom_range(0, 63)), pick_symbol(85),
                            k == 0, 1'b0, '0);
               end
            end else if (sel < 84) begin
               send_word(OP_LOAD_KEY,
                         ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, eff_key_len() - 1))
                                                      : 6'($urandom_range(0, 63)),
                         pick_symbol(80), 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (sel < 92) begin
               // Half of these duplicate a live symbol, so the highest match has to win.
               send_word(OP_LOAD_ALPHABET, 6'($urandom_range(0, 63)),
                         ($urandom_range(0, 1) == 1) ? pick_symbol(100) : pick_symbol(0),
                         1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (sel < 97) begin
               len = $urandom_range(1, 4);
               for (int k = 0; k < len; k++)
                  send_word(OP_MESSAGE, 6'($urandom_range(0, 63)), pick_symbol(40), 1'b0,
                            1'b0, '0);
            end else begin
               send_word(OP_RESERVED, 6'($urandom_range(0, 63)), pick_symbol(0),
                         1'($urandom_range(0, 1)), 1'b0, '0);
            end
         end
      end

      drain_engine();
      $display("Sent %0d words under %0d register settings and both cipher directions.",
               words_sent, settings_run);
      $display("Checked %0d result words, %0d of them with a symbol missing from the alphabet.",
               chars_checked, misses_checked);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
